[design/fltpe_pkg.sv]
`timescale 1ns / 1ps
package fltpe_pkg;

  localparam int MAX_TABLES_DEF    = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int USED_W            = 9;
  localparam int FRAME_W           = 40;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int ENTRY_W           = 64;

  localparam logic [VA_W-1:0] KERNEL_HALF_RESET = 48'h8000_0000_0000;

  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;
  localparam logic [1:0] OP_CHECK     = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_MAPPED  = 3'd1;
  localparam logic [2:0] ST_KERNEL_HALF = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED   = 3'd3;
  localparam logic [2:0] ST_NO_ACCESS   = 3'd4;

  localparam int E_PRESENT = 0;
  localparam int E_USER    = 2;

  localparam logic REG_POOL_FRAME  = 1'b0;
  localparam logic REG_KERNEL_HALF = 1'b1;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

[design/fltpe_mem.sv]
`timescale 1ns / 1ps
module fltpe_mem #(
  parameter int MAX_TABLES = fltpe_pkg::MAX_TABLES_DEF,
  parameter int AW = $clog2(MAX_TABLES) + fltpe_pkg::IDX_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fltpe_pkg::mem_ctl_t              ctl,
  input  logic [AW-1:0]                    addr,
  input  logic [fltpe_pkg::ENTRY_W-1:0]    wdata,
  output logic [fltpe_pkg::ENTRY_W-1:0]    rdata,
  output logic                             busy
);
  import fltpe_pkg::*;

  localparam int DEPTH = MAX_TABLES * ENTRIES_PER_TABLE;

  logic [ENTRY_W-1:0] store [DEPTH];
  logic [AW-1:0]      clr_addr;

  // zeroing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      store[clr_addr] <= '0;
    end else if (ctl.we) begin
      store[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= store[addr];
    end
  end

endmodule

[design/fltpe_walk.sv]
`timescale 1ns / 1ps
module fltpe_walk #(
  parameter int MAX_TABLES = fltpe_pkg::MAX_TABLES_DEF,
  parameter int TW = $clog2(MAX_TABLES),
  parameter int AW = TW + fltpe_pkg::IDX_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             mem_busy,
  input  logic [fltpe_pkg::FRAME_W-1:0]    pool_frame,
  input  logic [fltpe_pkg::VA_W-1:0]       kernel_half,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       op,
  input  logic [fltpe_pkg::VA_W-1:0]       virt_addr,
  input  logic [fltpe_pkg::PA_W-1:0]       phys_addr,
  input  logic                             user_flag,
  input  logic [1:0]                       cache_bits,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       status,
  output logic [fltpe_pkg::PA_W-1:0]       phys_result,
  output logic                             unmapped,
  output fltpe_pkg::mem_ctl_t              mem_ctl,
  output logic [AW-1:0]                    mem_addr,
  output logic [fltpe_pkg::ENTRY_W-1:0]    mem_wdata,
  input  logic [fltpe_pkg::ENTRY_W-1:0]    mem_rdata
);
  import fltpe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_LEAF = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]         st;
  logic [1:0]         lvl;
  logic               pass2;
  logic [TW-1:0]      tbl;
  logic [USED_W-1:0]  used;
  logic [1:0]         need;
  logic [1:0]         r_op;
  logic [VA_W-1:0]    r_va;
  logic [PA_W-1:0]    r_pa;
  logic               r_user;
  logic [1:0]         r_cache;
  logic [2:0]         res_status;
  logic [PA_W-1:0]    res_phys;
  logic               res_unm;

  logic [IDX_W-1:0]   idx;
  logic [FRAME_W-1:0] rel;
  logic               ok_up;
  logic               usr_fail;
  logic [FRAME_W-1:0] new_frame;

  assign in_ready = (st == S_IDLE) && !mem_busy;

  always_comb begin
    case (lvl)
      2'd0:    idx = r_va[47:39];
      2'd1:    idx = r_va[38:30];
      2'd2:    idx = r_va[29:21];
      default: idx = r_va[20:12];
    endcase
  end

  assign rel       = mem_rdata[51:12] - pool_frame;
  assign ok_up     = mem_rdata[E_PRESENT] && (rel < FRAME_W'(used));
  assign usr_fail  = (r_op == OP_CHECK) && !mem_rdata[E_USER];
  assign new_frame = pool_frame + FRAME_W'(used);
  assign mem_addr  = {tbl, idx};

  always_comb begin
    mem_ctl   = '0;
    mem_wdata = '0;
    case (st)
      S_RD: begin
        mem_ctl.re = 1'b1;
      end
      S_CHK: begin
        if (lvl != 2'd3) begin
          if (r_op == OP_MAP && pass2) begin
            if (ok_up) begin
              mem_ctl.we = r_user && !mem_rdata[E_USER];
              mem_wdata  = mem_rdata | (ENTRY_W'(1) << E_USER);
            end else begin
              mem_ctl.we = 1'b1;
              mem_wdata  = {12'b0, new_frame, 9'b0, r_user, 1'b1, 1'b1};
            end
          end
        end else if (r_op == OP_UNMAP && mem_rdata[E_PRESENT]) begin
          mem_ctl.we = 1'b1;
        end
      end
      S_LEAF: begin
        mem_ctl.we = 1'b1;
        mem_wdata  = {12'b0, r_pa[51:12], 7'b0, r_cache[1], r_cache[0], r_user,
                      1'b1, 1'b1};
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      used      <= USED_W'(1);
      out_valid <= 1'b0;
      lvl       <= '0;
      pass2     <= 1'b0;
      tbl       <= '0;
    end else begin
      if (out_valid && out_ready && st != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            r_op       <= op;
            r_va       <= virt_addr;
            r_pa       <= phys_addr;
            r_user     <= user_flag;
            r_cache    <= cache_bits;
            res_status <= ST_OK;
            res_phys   <= '0;
            res_unm    <= 1'b0;
            lvl        <= '0;
            tbl        <= '0;
            pass2      <= 1'b0;
            if (op == OP_MAP && user_flag && virt_addr >= kernel_half) begin
              res_status <= ST_KERNEL_HALF;
              st         <= S_FIN;
            end else begin
              st <= S_RD;
            end
          end
        end
        S_RD: begin
          st <= S_CHK;
        end
        S_CHK: begin
          if (lvl != 2'd3) begin
            if (r_op == OP_MAP && !pass2) begin
              if (!ok_up) begin
                need <= 2'd3 - lvl;
                st   <= S_DEC;
              end else begin
                tbl <= rel[TW-1:0];
                if (lvl == 2'd2) begin
                  need <= 2'd0;
                  st   <= S_DEC;
                end else begin
                  lvl <= lvl + 2'd1;
                  st  <= S_RD;
                end
              end
            end else if (r_op == OP_MAP) begin
              if (ok_up) begin
                tbl <= rel[TW-1:0];
              end else begin
                tbl  <= used[TW-1:0];
                used <= used + USED_W'(1);
              end
              lvl <= lvl + 2'd1;
              st  <= (lvl == 2'd2) ? S_LEAF : S_RD;
            end else if (usr_fail || !ok_up) begin
              res_status <= (r_op == OP_CHECK) ? ST_NO_ACCESS : ST_NOT_MAPPED;
              st         <= S_FIN;
            end else begin
              tbl <= rel[TW-1:0];
              lvl <= lvl + 2'd1;
              st  <= S_RD;
            end
          end else begin
            if (!mem_rdata[E_PRESENT] || usr_fail) begin
              res_status <= (r_op == OP_CHECK) ? ST_NO_ACCESS : ST_NOT_MAPPED;
            end else if (r_op == OP_UNMAP) begin
              res_unm <= 1'b1;
            end else if (r_op == OP_TRANSLATE) begin
              res_phys <= {mem_rdata[51:12], r_va[11:0]};
            end
            st <= S_FIN;
          end
        end
        S_DEC: begin
          if ({1'b0, used} + (USED_W + 1)'(need) > (USED_W + 1)'(MAX_TABLES)) begin
            res_status <= ST_EXHAUSTED;
            st         <= S_FIN;
          end else begin
            pass2 <= 1'b1;
            lvl   <= '0;
            tbl   <= '0;
            st    <= S_RD;
          end
        end
        S_LEAF: begin
          st <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            status      <= res_status;
            phys_result <= res_phys;
            unmapped    <= res_unm;
            out_valid   <= 1'b1;
            st          <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/four_level_page_table_engine_core.sv]
`timescale 1ns / 1ps
// channel   direction  handshake            beat
// in        input      in_valid/in_ready    op, virt_addr, phys_addr, user_flag, cache_bits
// out       output     out_valid/out_ready  status, phys_result, unmapped
// apb       input      psel/penable/pready  table_pool_frame at 0x0, kernel_half_start at 0x8
//
// one beat at a time: each table level takes a read state and a check state on the
// single-port table memory, so unmap, translate and check walk the levels at most once,
// map runs a counting walk, then an allocating walk and a leaf write
// after reset a zeroing sweep over all MAX_TABLES*512 entries runs before in_ready rises
// a result waiting on out_ready holds the finished beat; the next beat may enter
module four_level_page_table_engine_core #(
  parameter int MAX_TABLES = fltpe_pkg::MAX_TABLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [fltpe_pkg::VA_W-1:0]    virt_addr,
  input  logic [fltpe_pkg::PA_W-1:0]    phys_addr,
  input  logic                          user_flag,
  input  logic [1:0]                    cache_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [fltpe_pkg::PA_W-1:0]    phys_result,
  output logic                          unmapped
);
  import fltpe_pkg::*;

  localparam int TW = $clog2(MAX_TABLES);
  localparam int AW = TW + IDX_W;

  logic [FRAME_W-1:0] pool_frame;
  logic [VA_W-1:0]    kernel_half;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_busy;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_KERNEL_HALF) ? {16'b0, kernel_half} : {24'b0, pool_frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_frame  <= '0;
      kernel_half <= KERNEL_HALF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == REG_POOL_FRAME) begin
        pool_frame <= pwdata[FRAME_W-1:0];
      end else begin
        kernel_half <= pwdata[VA_W-1:0];
      end
    end
  end

  fltpe_mem #(.MAX_TABLES(MAX_TABLES), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  fltpe_walk #(.MAX_TABLES(MAX_TABLES), .TW(TW), .AW(AW)) u_walk (
    .clk         (clk),
    .rst         (rst),
    .mem_busy    (mem_busy),
    .pool_frame  (pool_frame),
    .kernel_half (kernel_half),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .user_flag   (user_flag),
    .cache_bits  (cache_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .phys_result (phys_result),
    .unmapped    (unmapped),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

endmodule

[design/fltpe_checker.sv]
`timescale 1ns / 1ps
module fltpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [51:0] phys_result,
  input logic        unmapped
);
  import fltpe_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(phys_result))
    else $error("result beat changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NO_ACCESS)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> phys_result == '0 && !unmapped)
    else $error("failed beat carries data");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && unmapped |-> phys_result == '0)
    else $error("unmap beat carries an address");

endmodule

bind four_level_page_table_engine_core fltpe_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .phys_result (phys_result),
  .unmapped    (unmapped)
);
